// ===== hw/rtl/sjf_dispatch_scheduler_unit_assert.svh =====
// assertion macros shared by the scheduler modules
// expects i_clk and i_rst_n in the module that uses them
`ifndef SJF_DISPATCH_SCHEDULER_UNIT_ASSERT_SVH
`define SJF_DISPATCH_SCHEDULER_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SJF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define SJF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sjfds_pkg.sv =====
// shared types, codes and default sizes for the sjf dispatch scheduler
// no dependencies
`default_nettype none

package sjfds_pkg;

    // default sizes
    localparam int SLOTS_DEF      = 16;
    localparam int BURST_BITS_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;

    // fixed port widths
    localparam int SLOT_W   = 4;
    localparam int BURST_W  = 16;
    localparam int IO_W     = 16;
    localparam int STATUS_W = 2;
    localparam int OTIME_W  = 32;
    localparam int BUSY_W   = 32;

    // item kinds
    localparam logic KIND_POST = 1'b0;
    localparam logic KIND_DISP = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_POSTED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DISPATCH = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE     = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic capture;   // latch item fields, read the posted slot
        logic scan_clr;  // clear best candidates before a scan
        logic scan_rd;   // read slot at scan index
        logic decide;    // pick the winner, work out start and end
        logic commit;    // write back the dispatch, load the result
        logic post_wr;   // write the posted slot, load the result
        logic rej;       // load a rejected post result
        logic none;      // load a nothing-pending result
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic post_bad;  // item on the inputs is a post that must be rejected
        logic any_pend;  // at least one slot holds a burst
    } t_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/sjfds_dpath.sv =====
// datapath: slot tables, scan compare, time and busy accumulators, result beat
// depends on sjfds_pkg and sjf_dispatch_scheduler_unit_assert.svh
`default_nettype none
`include "sjf_dispatch_scheduler_unit_assert.svh"

module sjfds_dpath #(
    parameter int SLOTS      = sjfds_pkg::SLOTS_DEF,
    parameter int BURST_BITS = sjfds_pkg::BURST_BITS_DEF,
    parameter int TIME_BITS  = sjfds_pkg::TIME_BITS_DEF,
    localparam int SIDX      = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire  sjfds_pkg::t_cmd                 i_cmd,
    input  wire  [SIDX-1:0]                       i_idx,
    input  wire  [sjfds_pkg::SLOT_W-1:0]          i_slot,
    input  wire  [sjfds_pkg::BURST_W-1:0]         i_burst,
    input  wire  [sjfds_pkg::IO_W-1:0]            i_io_delay,
    output sjfds_pkg::t_stat                      o_stat,
    output logic [sjfds_pkg::STATUS_W-1:0]        o_status,
    output logic [sjfds_pkg::SLOT_W-1:0]          o_chosen_slot,
    output logic [sjfds_pkg::BURST_W-1:0]         o_run_length,
    output logic [sjfds_pkg::OTIME_W-1:0]         o_start_time,
    output logic [sjfds_pkg::OTIME_W-1:0]         o_end_time,
    output logic                                  o_first_dispatch,
    output logic [sjfds_pkg::BUSY_W-1:0]          o_busy_total
);

    localparam int SUMW   = ((TIME_BITS > BURST_BITS) ? TIME_BITS : BURST_BITS) + 1;
    localparam int BSUM_W = sjfds_pkg::BUSY_W + 1;

    // slot tables
    logic [BURST_BITS-1:0] m_burst [SLOTS];
    logic [TIME_BITS-1:0]  m_ready [SLOTS];
    logic [SLOTS-1:0]      r_pend;
    logic [SLOTS-1:0]      r_rtw;
    logic [SLOTS-1:0]      r_ran;

    logic [TIME_BITS-1:0]  r_cur;
    logic [sjfds_pkg::BUSY_W-1:0] r_busy;

    // captured item
    logic [sjfds_pkg::SLOT_W-1:0] r_slot;
    logic [BURST_BITS-1:0]        r_bin;
    logic [sjfds_pkg::IO_W-1:0]   r_io;

    // registered read data
    logic [BURST_BITS-1:0] r_burst_q;
    logic [TIME_BITS-1:0]  r_ready_q;

    // scan compare stage
    logic                  r_cmp_en;
    logic [SIDX-1:0]       r_cmp_idx;
    logic                  r_a_f;
    logic [SIDX-1:0]       r_a_idx;
    logic [BURST_BITS-1:0] r_a_b;
    logic [TIME_BITS-1:0]  r_a_rt;
    logic                  r_b_f;
    logic [SIDX-1:0]       r_b_idx;
    logic [BURST_BITS-1:0] r_b_b;
    logic [TIME_BITS-1:0]  r_b_rt;

    // decided dispatch
    logic [SIDX-1:0]       r_pick;
    logic [BURST_BITS-1:0] r_pb;
    logic [TIME_BITS-1:0]  r_start;
    logic [TIME_BITS-1:0]  r_end;

    logic [BURST_BITS-1:0] bin_in;
    logic [SIDX-1:0]       in_idx;
    logic                  in_range;
    logic [SIDX-1:0]       rd_idx;
    logic [SIDX-1:0]       ws_idx;
    logic [TIME_BITS-1:0]  ready_rd;
    logic [TIME_BITS:0]    post_sum;
    logic [TIME_BITS-1:0]  post_new;
    logic                  cmp_pend;
    logic                  take_a;
    logic                  take_b;
    logic [SIDX-1:0]       dec_idx;
    logic [BURST_BITS-1:0] dec_b;
    logic [TIME_BITS-1:0]  dec_start;
    logic [SUMW-1:0]       end_sum;
    logic [TIME_BITS-1:0]  dec_end;
    logic [BSUM_W-1:0]     busy_sum;
    logic [sjfds_pkg::BUSY_W-1:0] busy_nx;

    // input decode and post check
    assign bin_in   = BURST_BITS'(i_burst);
    assign in_idx   = SIDX'(i_slot);
    assign in_range = (32'(i_slot) < 32'(SLOTS));
    assign o_stat.post_bad = !in_range || (bin_in == '0) || r_pend[in_idx];
    assign o_stat.any_pend = |r_pend;

    assign rd_idx = i_cmd.capture ? in_idx : i_idx;
    assign ws_idx = SIDX'(r_slot);

    // table reads, one address per cycle
    always_ff @(posedge i_clk) begin
        r_burst_q <= m_burst[rd_idx];
        r_ready_q <= m_ready[rd_idx];
    end

    // table writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.post_wr) begin
            m_burst[ws_idx] <= r_bin;
            m_ready[ws_idx] <= post_new;
        end else if (i_cmd.commit) begin
            m_ready[r_pick] <= r_end;
        end
    end

    // post: saturating ready time update
    always_comb begin
        ready_rd = r_rtw[ws_idx] ? r_ready_q : '0;
        post_sum = {1'b0, ready_rd} + (TIME_BITS+1)'(r_io);
        post_new = post_sum[TIME_BITS] ? '1 : post_sum[TIME_BITS-1:0];
    end

    // scan compare: best ready slot and earliest pending slot
    always_comb begin
        cmp_pend = r_pend[r_cmp_idx];
        take_a = r_cmp_en && cmp_pend && (r_ready_q <= r_cur) &&
                 (!r_a_f || (r_burst_q < r_a_b) ||
                  ((r_burst_q == r_a_b) && (r_ready_q < r_a_rt)));
        take_b = r_cmp_en && cmp_pend &&
                 (!r_b_f || (r_ready_q < r_b_rt) ||
                  ((r_ready_q == r_b_rt) && (r_burst_q < r_b_b)));
    end

    // decide: winner, start time and saturating end time
    always_comb begin
        dec_idx   = r_a_f ? r_a_idx : r_b_idx;
        dec_b     = r_a_f ? r_a_b : r_b_b;
        dec_start = r_a_f ? r_cur : r_b_rt;
        end_sum   = SUMW'(dec_start) + SUMW'(dec_b);
        dec_end   = (end_sum[SUMW-1:TIME_BITS] != '0) ? '1 : end_sum[TIME_BITS-1:0];
    end

    // saturating busy total
    always_comb begin
        busy_sum = BSUM_W'(r_busy) + BSUM_W'(r_pb);
        busy_nx  = busy_sum[BSUM_W-1] ? '1 : busy_sum[sjfds_pkg::BUSY_W-1:0];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= '0;
            r_rtw    <= '0;
            r_ran    <= '0;
            r_cur    <= '0;
            r_busy   <= '0;
            r_cmp_en <= 1'b0;
            r_a_f    <= 1'b0;
            r_b_f    <= 1'b0;
        end else begin
            r_cmp_en <= i_cmd.scan_rd;
            if (i_cmd.post_wr) begin
                r_pend[ws_idx] <= 1'b1;
                r_rtw[ws_idx]  <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_pend[r_pick] <= 1'b0;
                r_ran[r_pick]  <= 1'b1;
                r_cur          <= r_end;
                r_busy         <= busy_nx;
            end
            if (i_cmd.scan_clr) begin
                r_a_f <= 1'b0;
                r_b_f <= 1'b0;
            end else begin
                if (take_a) r_a_f <= 1'b1;
                if (take_b) r_b_f <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= i_idx;
        if (i_cmd.capture) begin
            r_slot <= i_slot;
            r_bin  <= bin_in;
            r_io   <= i_io_delay;
        end
        if (take_a) begin
            r_a_idx <= r_cmp_idx;
            r_a_b   <= r_burst_q;
            r_a_rt  <= r_ready_q;
        end
        if (take_b) begin
            r_b_idx <= r_cmp_idx;
            r_b_b   <= r_burst_q;
            r_b_rt  <= r_ready_q;
        end
        if (i_cmd.decide) begin
            r_pick  <= dec_idx;
            r_pb    <= dec_b;
            r_start <= dec_start;
            r_end   <= dec_end;
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.rej || i_cmd.none) begin
            o_status         <= i_cmd.rej ? sjfds_pkg::ST_REJECTED : sjfds_pkg::ST_NONE;
            o_chosen_slot    <= i_cmd.rej ? i_slot : '0;
            o_run_length     <= '0;
            o_start_time     <= '0;
            o_end_time       <= '0;
            o_first_dispatch <= 1'b0;
            o_busy_total     <= r_busy;
        end else if (i_cmd.post_wr) begin
            o_status         <= sjfds_pkg::ST_POSTED;
            o_chosen_slot    <= r_slot;
            o_run_length     <= '0;
            o_start_time     <= '0;
            o_end_time       <= '0;
            o_first_dispatch <= 1'b0;
            o_busy_total     <= r_busy;
        end else if (i_cmd.commit) begin
            o_status         <= sjfds_pkg::ST_DISPATCH;
            o_chosen_slot    <= sjfds_pkg::SLOT_W'(r_pick);
            o_run_length     <= sjfds_pkg::BURST_W'(r_pb);
            o_start_time     <= sjfds_pkg::OTIME_W'(r_start);
            o_end_time       <= sjfds_pkg::OTIME_W'(r_end);
            o_first_dispatch <= !r_ran[r_pick];
            o_busy_total     <= busy_nx;
        end
    end

    // checks
    `SJF_ASSERT_SAME(a_decide_has_cand, i_cmd.decide, r_a_f || r_b_f, "decide without candidate")
    `SJF_ASSERT_SAME(a_commit_pending, i_cmd.commit, r_pend[r_pick], "commit of empty slot")
    `SJF_ASSERT_NEXT(a_time_monotonic, i_cmd.commit, r_cur >= $past(r_cur), "time went back")

endmodule

`default_nettype wire

// ===== hw/rtl/sjfds_ctrl.sv =====
// controller: sequences post, slot scan, decide and write-back; drives the strobe
// depends on sjfds_pkg and sjf_dispatch_scheduler_unit_assert.svh
`default_nettype none
`include "sjf_dispatch_scheduler_unit_assert.svh"

module sjfds_ctrl #(
    parameter int SLOTS = sjfds_pkg::SLOTS_DEF,
    localparam int SIDX = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    start,
    input  wire                    i_kind,
    input  wire  sjfds_pkg::t_stat i_stat,
    output logic                   busy,
    output logic                   o_strobe,
    output sjfds_pkg::t_cmd        o_cmd,
    output logic [SIDX-1:0]        o_idx
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_POST   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_COMMIT = 3'd5;

    localparam logic [SIDX-1:0] LAST_IDX = SIDX'(SLOTS - 1);

    logic [2:0]      r_state;
    logic [2:0]      n_state;
    logic [SIDX-1:0] r_cnt;
    logic [SIDX-1:0] n_cnt;
    logic            r_strobe;
    logic            n_strobe;
    logic            accept;

    assign accept   = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_idx    = r_cnt;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    if (i_kind == sjfds_pkg::KIND_DISP) begin
                        if (i_stat.any_pend) begin
                            o_cmd.scan_clr = 1'b1;
                            n_cnt          = '0;
                            n_state        = S_SCAN;
                        end else begin
                            o_cmd.none = 1'b1;
                        end
                    end else if (i_stat.post_bad) begin
                        o_cmd.rej = 1'b1;
                    end else begin
                        n_state = S_POST;
                    end
                end
            end
            S_POST: begin
                o_cmd.post_wr = 1'b1;
                n_state       = S_IDLE;
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_strobe = o_cmd.rej || o_cmd.none || o_cmd.post_wr || o_cmd.commit;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_strobe <= n_strobe;
        end
    end

    // checks
    `SJF_ASSERT_SAME(a_strobe_when_idle, r_strobe, !busy, "result beat while busy")
    `SJF_ASSERT_NEXT(a_accept_progress, accept, r_strobe || busy, "accepted item dropped")

endmodule

`default_nettype wire

// ===== hw/rtl/sjf_dispatch_scheduler_unit.sv =====
// Shortest-job-first dispatch scheduler. An item is taken when start is high and
// busy is low. A rejected post or a dispatch with no pending slot gives its result
// beat on the next cycle and leaves busy low; an accepted post writes its slot in
// the post state first. A dispatch does one slot table read per cycle through a
// single compare stage, then has a drain state for the last read, a decide state
// that picks the winner and works out the end time, and a commit state that
// writes back before its result beat. Each result is on the outputs for exactly
// one cycle while o_strobe is high; there is no backpressure, so the receiver
// must take it then.
// depends on sjfds_pkg, sjfds_ctrl and sjfds_dpath
`default_nettype none

module sjf_dispatch_scheduler_unit #(
    parameter int SLOTS      = sjfds_pkg::SLOTS_DEF,
    parameter int BURST_BITS = sjfds_pkg::BURST_BITS_DEF,
    parameter int TIME_BITS  = sjfds_pkg::TIME_BITS_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   start,
    output logic                                  busy,
    input  wire                                   i_kind,
    input  wire  [sjfds_pkg::SLOT_W-1:0]          i_slot,
    input  wire  [sjfds_pkg::BURST_W-1:0]         i_burst,
    input  wire  [sjfds_pkg::IO_W-1:0]            i_io_delay,
    output logic                                  o_strobe,
    output logic [sjfds_pkg::STATUS_W-1:0]        o_status,
    output logic [sjfds_pkg::SLOT_W-1:0]          o_chosen_slot,
    output logic [sjfds_pkg::BURST_W-1:0]         o_run_length,
    output logic [sjfds_pkg::OTIME_W-1:0]         o_start_time,
    output logic [sjfds_pkg::OTIME_W-1:0]         o_end_time,
    output logic                                  o_first_dispatch,
    output logic [sjfds_pkg::BUSY_W-1:0]          o_busy_total
);

    localparam int SIDX = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    sjfds_pkg::t_cmd  cmd;
    sjfds_pkg::t_stat stat;
    logic [SIDX-1:0]  scan_idx;

    // sequencer
    sjfds_ctrl #(
        .SLOTS(SLOTS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_kind  (i_kind),
        .i_stat  (stat),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_cmd   (cmd),
        .o_idx   (scan_idx)
    );

    // slot tables and arithmetic
    sjfds_dpath #(
        .SLOTS     (SLOTS),
        .BURST_BITS(BURST_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_idx           (scan_idx),
        .i_slot          (i_slot),
        .i_burst         (i_burst),
        .i_io_delay      (i_io_delay),
        .o_stat          (stat),
        .o_status        (o_status),
        .o_chosen_slot   (o_chosen_slot),
        .o_run_length    (o_run_length),
        .o_start_time    (o_start_time),
        .o_end_time      (o_end_time),
        .o_first_dispatch(o_first_dispatch),
        .o_busy_total    (o_busy_total)
    );

endmodule

`default_nettype wire

// ===== bench/sjf_dispatch_scheduler_unit_test.sv =====
// self-checking testbench for the sjf dispatch scheduler: drives post and dispatch beats
// and checks each result beat against a cycle-free scheduler predictor
// depends on sjfds_pkg and sjf_dispatch_scheduler_unit
`timescale 1ns / 100ps

module sjf_dispatch_scheduler_unit_test;
    import sjfds_pkg::*;

    localparam int NSLOT = SLOTS_DEF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [BURST_W-1:0]  run;
        logic [OTIME_W-1:0]  t_begin;
        logic [OTIME_W-1:0]  t_end;
        logic                first;
        logic [BUSY_W-1:0]   busy;
    } t_sched_result;

    // clock, reset and block inputs
    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                start      = 1'b0;
    logic                i_kind     = KIND_POST;
    logic [SLOT_W-1:0]   i_slot     = '0;
    logic [BURST_W-1:0]  i_burst    = '0;
    logic [IO_W-1:0]     i_io_delay = '0;

    logic                busy;
    logic                o_strobe;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0]   o_chosen_slot;
    logic [BURST_W-1:0]  o_run_length;
    logic [OTIME_W-1:0]  o_start_time;
    logic [OTIME_W-1:0]  o_end_time;
    logic                o_first_dispatch;
    logic [BUSY_W-1:0]   o_busy_total;

    // scheduler state as predicted
    logic [BURST_W-1:0]  job_len   [NSLOT];
    logic [OTIME_W-1:0]  job_ready [NSLOT];
    logic                job_ran   [NSLOT];
    logic [OTIME_W-1:0]  clock_now;
    logic [BUSY_W-1:0]   cpu_busy;

    t_sched_result pending_results[$];
    int            mismatches = 0;
    int            idle_pct   = 0;

    sjf_dispatch_scheduler_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_kind           (i_kind),
        .i_slot           (i_slot),
        .i_burst          (i_burst),
        .i_io_delay       (i_io_delay),
        .o_strobe         (o_strobe),
        .o_status         (o_status),
        .o_chosen_slot    (o_chosen_slot),
        .o_run_length     (o_run_length),
        .o_start_time     (o_start_time),
        .o_end_time       (o_end_time),
        .o_first_dispatch (o_first_dispatch),
        .o_busy_total     (o_busy_total)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // advance the predicted scheduler by one beat and return its result
    function automatic t_sched_result schedule_item(input logic kind,
                                                    input logic [SLOT_W-1:0] slot,
                                                    input logic [BURST_W-1:0] burst,
                                                    input logic [IO_W-1:0] io);
        t_sched_result res;
        logic          any_pend;
        logic          found;
        logic [31:0]   earliest;
        int            pick;
        res      = '0;
        any_pend = 1'b0;
        found    = 1'b0;
        earliest = '0;
        pick     = 0;
        if (kind == KIND_POST) begin
            res.slot = slot;
            if (burst == '0 || job_len[slot] != '0) begin
                res.status = ST_REJECTED;
            end else begin
                job_len[slot]   = burst;
                job_ready[slot] = add_sat(job_ready[slot], 32'(io));
                res.status      = ST_POSTED;
            end
            res.busy = cpu_busy;
            return res;
        end
        // earliest ready time among pending slots
        for (int i = 0; i < NSLOT; i++) begin
            if (job_len[i] != '0) begin
                if (!any_pend || job_ready[i] < earliest) earliest = job_ready[i];
                any_pend = 1'b1;
            end
        end
        if (!any_pend) begin
            res.status = ST_NONE;
            res.busy   = cpu_busy;
            return res;
        end
        if (earliest > clock_now) clock_now = earliest;
        // shortest ready burst, then earlier ready time, then lower slot
        for (int i = 0; i < NSLOT; i++) begin
            if (job_len[i] != '0 && job_ready[i] <= clock_now) begin
                if (!found || job_len[i] < job_len[pick] ||
                    (job_len[i] == job_len[pick] && job_ready[i] < job_ready[pick])) begin
                    pick  = i;
                    found = 1'b1;
                end
            end
        end
        if (!found) begin
            res.status = ST_NONE;
            res.busy   = cpu_busy;
            return res;
        end
        res.status      = ST_DISPATCH;
        res.slot        = SLOT_W'(pick);
        res.run         = job_len[pick];
        res.t_begin     = clock_now;
        res.t_end       = add_sat(clock_now, 32'(job_len[pick]));
        res.first       = !job_ran[pick];
        cpu_busy        = add_sat(cpu_busy, 32'(job_len[pick]));
        clock_now       = res.t_end;
        job_ready[pick] = res.t_end;
        job_ran[pick]   = 1'b1;
        job_len[pick]   = '0;
        res.busy        = cpu_busy;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 40)
            $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // send one beat, with a random sender gap first; start stays high afterward
    task automatic issue_item(input logic kind, input logic [SLOT_W-1:0] slot,
                              input logic [BURST_W-1:0] burst, input logic [IO_W-1:0] io);
        int gap;
        gap = 0;
        while (gap < 24 && $urandom_range(0, 99) < idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_kind     <= kind;
        i_slot     <= slot;
        i_burst    <= burst;
        i_io_delay <= io;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(schedule_item(kind, slot, burst, io));
    endtask

    // result beat checker
    always @(posedge i_clk) begin
        t_sched_result want;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat, status", 32'(o_status), '0);
            end else begin
                want = pending_results.pop_front();
                if (o_status != want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_chosen_slot != want.slot)
                    report_mismatch("chosen_slot", 32'(o_chosen_slot), 32'(want.slot));
                if (o_run_length != want.run)
                    report_mismatch("run_length", 32'(o_run_length), 32'(want.run));
                if (o_start_time != want.t_begin)
                    report_mismatch("start_time", o_start_time, want.t_begin);
                if (o_end_time != want.t_end)
                    report_mismatch("end_time", o_end_time, want.t_end);
                if (o_first_dispatch != want.first)
                    report_mismatch("first_dispatch", 32'(o_first_dispatch), 32'(want.first));
                if (o_busy_total != want.busy)
                    report_mismatch("busy_total", o_busy_total, want.busy);
            end
        end
    end

    // post rules: empty dispatch after reset, busy slot, zero burst, field extremes
    task automatic test_post_rules();
        issue_item(KIND_DISP, 4'd0, 16'd0, 16'd0);          // nothing pending after reset
        issue_item(KIND_POST, 4'd0, 16'd1, 16'd0);
        issue_item(KIND_POST, 4'd0, 16'd7, 16'd0);          // slot still holds a burst
        issue_item(KIND_POST, 4'd15, 16'd0, 16'd5);         // zero burst
        issue_item(KIND_POST, 4'd15, 16'hFFFF, 16'hFFFF);
        issue_item(KIND_POST, 4'd9, 16'd100, 16'd0);
        issue_item(KIND_POST, 4'd3, 16'd100, 16'd0);
        issue_item(KIND_POST, 4'd6, 16'd100, 16'd50);
    endtask

    // dispatch order: shortest first, ready-time tie break, slot tie break, idle jump
    task automatic test_dispatch_order();
        issue_item(KIND_DISP, 4'hF, 16'hFFFF, 16'hFFFF);    // shortest burst
        issue_item(KIND_DISP, 4'd0, 16'd0, 16'd0);          // equal burst and ready: lower slot
        issue_item(KIND_DISP, 4'd0, 16'd0, 16'd0);          // equal burst: earlier ready
        issue_item(KIND_DISP, 4'd0, 16'd0, 16'd0);
        issue_item(KIND_DISP, 4'd0, 16'd0, 16'd0);          // time jumps to ready time
        issue_item(KIND_DISP, 4'd0, 16'd0, 16'd0);          // table empty again
        issue_item(KIND_POST, 4'd0, 16'hAAAA, 16'h5555);
        issue_item(KIND_POST, 4'd0, 16'h5555, 16'h0);
        issue_item(KIND_POST, 4'd1, 16'h5555, 16'hAAAA);
        issue_item(KIND_DISP, 4'd0, 16'd0, 16'd0);          // slot 1 first, shorter burst; slot 0 repeats next
        issue_item(KIND_DISP, 4'd0, 16'd0, 16'd0);
    endtask

    // mixed traffic, mostly posts to empty slots and dispatches
    task automatic test_random_traffic(input int count);
        logic [SLOT_W-1:0]  slot;
        logic [BURST_W-1:0] burst;
        logic [IO_W-1:0]    io;
        int                 empties[$];
        for (int n = 0; n < count; n++) begin
            slot = SLOT_W'($urandom_range(0, NSLOT - 1));
            case ($urandom_range(0, 9))
                0:       burst = '0;
                1, 2, 3: burst = BURST_W'($urandom_range(1, 15));
                4:       burst = '1;
                5:       burst = BURST_W'(1) << $urandom_range(0, BURST_W - 1);
                6:       burst = ~(BURST_W'(1) << $urandom_range(0, BURST_W - 1));
                default: burst = BURST_W'($urandom_range(1, 65535));
            endcase
            case ($urandom_range(0, 5))
                0, 1:    io = '0;
                2:       io = IO_W'($urandom_range(1, 64));
                3:       io = '1;
                default: io = IO_W'($urandom_range(0, 65535));
            endcase
            if ($urandom_range(0, 99) < 40) begin
                issue_item(KIND_DISP, slot, burst, io);
            end else begin
                empties.delete();
                for (int i = 0; i < NSLOT; i++)
                    if (job_len[i] == '0) empties.push_back(i);
                if (empties.size() > 0 && $urandom_range(0, 99) < 70)
                    slot = SLOT_W'(empties[$urandom_range(0, empties.size() - 1)]);
                issue_item(KIND_POST, slot, burst, io);
            end
        end
    endtask

    // long bursts and long i/o waits push time and the busy total up
    task automatic test_long_bursts(input int pairs);
        for (int n = 0; n < pairs; n++) begin
            issue_item(KIND_POST, SLOT_W'($urandom_range(0, NSLOT - 1)), 16'hFFFF, 16'hFFFF);
            issue_item(KIND_DISP, SLOT_W'($urandom), BURST_W'($urandom), IO_W'($urandom));
        end
        test_random_traffic(20);
    endtask

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            job_len[i]   = '0;
            job_ready[i] = '0;
            job_ran[i]   = 1'b0;
        end
        clock_now = '0;
        cpu_busy  = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 12;
        test_post_rules();
        test_dispatch_order();
        test_random_traffic(110);
        idle_pct = 63;
        test_random_traffic(110);
        idle_pct = 0;
        test_random_traffic(110);
        test_long_bursts(16);

        // drain outstanding results, then watch for stray beats
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (NSLOT + 8) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("sjf_dispatch_scheduler_unit_test: done, clean");
        end else begin
            $display("sjf_dispatch_scheduler_unit_test: done, errors");
        end
        $finish;
    end

    // run limit, several times the slowest correct run
    initial begin
        #2_000_000;
        $display("timeout waiting on handshake");
        $display("sjf_dispatch_scheduler_unit_test: done, errors");
        $finish;
    end

endmodule
